// ===== rtl/hsv2rgb_pkg.sv =====
// Shared widths, constants, sector codes and types for the HSV to RGB pipeline.
`timescale 1ns / 1ps
package hsv2rgb_pkg;

  localparam int HUE_W   = 16;
  localparam int PCT_W   = 7;
  localparam int LVL_W   = 8;
  localparam int ANGLE_W = 9;
  localparam int SECT_W  = 3;
  localparam int OFFS_W  = 6;

  localparam int HUE_CIRCLE  = 360;
  localparam int SECTOR_SPAN = 60;
  localparam int PCT_FULL    = 100;
  localparam int LEVEL_FULL  = 255;

  // Reciprocal multipliers: floor(x / d) == (x * RECIP) >> SHIFT over each operand range
  localparam int HUE_RECIP  = 46604;
  localparam int HUE_SHIFT  = 24;
  localparam int SECT_RECIP = 1093;
  localparam int SECT_SHIFT = 16;
  localparam int PCT_RECIP  = 5243;
  localparam int PCT_SHIFT  = 19;
  localparam int RAMP_RECIP = 17477;
  localparam int RAMP_SHIFT = 20;

  typedef logic [SECT_W-1:0] sector_t;
  typedef logic [LVL_W-1:0]  level_t;
  typedef logic [PCT_W-1:0]  pct_t;
  typedef logic [OFFS_W-1:0] offset_t;

  localparam sector_t SECT_RED_YEL = 3'd0;
  localparam sector_t SECT_YEL_GRN = 3'd1;
  localparam sector_t SECT_GRN_CYN = 3'd2;
  localparam sector_t SECT_CYN_BLU = 3'd3;
  localparam sector_t SECT_BLU_MAG = 3'd4;
  localparam sector_t SECT_MAG_RED = 3'd5;

  typedef struct packed {
    logic    valid;
    sector_t sector;
    offset_t offset;
  } hue_info_t;

  function automatic pct_t clamp_pct(input pct_t p);
    clamp_pct = (p > pct_t'(PCT_FULL)) ? pct_t'(PCT_FULL) : p;
  endfunction

endpackage

// ===== rtl/hsv2rgb_hue_split.sv =====
// Hue path: reduce modulo 360, then split into sector and offset over four stages.
`timescale 1ns / 1ps
module hsv2rgb_hue_split (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  input  logic [hsv2rgb_pkg::HUE_W-1:0]       in_hue,
  output hsv2rgb_pkg::hue_info_t              hue_info
);
  import hsv2rgb_pkg::*;

  localparam int QPROD_W = 2 * HUE_W;
  localparam int REM_W   = ANGLE_W + 8;
  localparam int SPROD_W = 19;

  logic [3:0]           valid_r;
  logic [HUE_W-1:0]     hue_r;
  logic [QPROD_W-1:0]   qprod_r, qprod_nxt;
  logic [ANGLE_W-1:0]   angle2_r, angle2_nxt;
  logic [ANGLE_W-1:0]   angle3_r;
  sector_t              sector3_r, sector3_nxt;
  sector_t              sector4_r;
  offset_t              offset4_r, offset4_nxt;
  logic [7:0]           quo;
  logic [REM_W-1:0]     rem_full;
  logic [SPROD_W-1:0]   sprod;
  logic [ANGLE_W-1:0]   offs_full;

  always_comb begin
    qprod_nxt   = QPROD_W'(in_hue) * QPROD_W'(HUE_RECIP);
    quo         = 8'(qprod_r >> HUE_SHIFT);
    rem_full    = REM_W'(hue_r) - (REM_W'(quo) * REM_W'(HUE_CIRCLE));
    angle2_nxt  = rem_full[ANGLE_W-1:0];
    sprod       = SPROD_W'(angle2_r) * SPROD_W'(SECT_RECIP);
    sector3_nxt = SECT_W'(sprod >> SECT_SHIFT);
    offs_full   = angle3_r - (ANGLE_W'(sector3_r) * ANGLE_W'(SECTOR_SPAN));
    offset4_nxt = offs_full[OFFS_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else begin
      valid_r <= {valid_r[2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    hue_r     <= in_hue;
    qprod_r   <= qprod_nxt;
    angle2_r  <= angle2_nxt;
    angle3_r  <= angle2_r;
    sector3_r <= sector3_nxt;
    sector4_r <= sector3_r;
    offset4_r <= offset4_nxt;
  end

  assign hue_info.valid  = valid_r[3];
  assign hue_info.sector = sector4_r;
  assign hue_info.offset = offset4_r;

endmodule

// ===== rtl/hsv2rgb_level.sv =====
// Level path: clamp percentages, derive peak and floor levels over four stages.
`timescale 1ns / 1ps
module hsv2rgb_level (
  input  logic                          clk,
  input  logic [hsv2rgb_pkg::PCT_W-1:0] in_saturation,
  input  logic [hsv2rgb_pkg::PCT_W-1:0] in_brightness,
  output hsv2rgb_pkg::level_t           peak,
  output hsv2rgb_pkg::level_t           low
);
  import hsv2rgb_pkg::*;

  localparam int VPROD_W = 15;
  localparam int DPROD_W = 28;

  pct_t                sat1_r, sat2_r;
  logic [VPROD_W-1:0]  vprod_r, vprod_nxt;
  level_t              peak2_r, peak2_nxt;
  level_t              peak3_r, peak4_r;
  logic [VPROD_W-1:0]  lprod_r, lprod_nxt;
  level_t              low4_r, low4_nxt;
  logic [DPROD_W-1:0]  pdiv, ldiv;

  always_comb begin
    vprod_nxt = VPROD_W'(clamp_pct(in_brightness)) * VPROD_W'(LEVEL_FULL);
    pdiv      = DPROD_W'(vprod_r) * DPROD_W'(PCT_RECIP);
    peak2_nxt = LVL_W'(pdiv >> PCT_SHIFT);
    lprod_nxt = VPROD_W'(peak2_r) * VPROD_W'(pct_t'(PCT_FULL) - sat2_r);
    ldiv      = DPROD_W'(lprod_r) * DPROD_W'(PCT_RECIP);
    low4_nxt  = LVL_W'(ldiv >> PCT_SHIFT);
  end

  always_ff @(posedge clk) begin
    sat1_r  <= clamp_pct(in_saturation);
    vprod_r <= vprod_nxt;
    sat2_r  <= sat1_r;
    peak2_r <= peak2_nxt;
    peak3_r <= peak2_r;
    lprod_r <= lprod_nxt;
    peak4_r <= peak3_r;
    low4_r  <= low4_nxt;
  end

  assign peak = peak4_r;
  assign low  = low4_r;

endmodule

// ===== rtl/hsv2rgb_mix.sv =====
// Mix stages: ramp from level span and offset, then route per sector to RGB.
`timescale 1ns / 1ps
module hsv2rgb_mix (
  input  logic                   clk,
  input  logic                   rst_n,
  input  hsv2rgb_pkg::hue_info_t hue_info,
  input  hsv2rgb_pkg::level_t    peak,
  input  hsv2rgb_pkg::level_t    low,
  output logic                   out_valid,
  output hsv2rgb_pkg::level_t    out_red,
  output hsv2rgb_pkg::level_t    out_green,
  output hsv2rgb_pkg::level_t    out_blue
);
  import hsv2rgb_pkg::*;

  localparam int SPAN_W = 14;
  localparam int RPROD_W = 29;

  logic [2:0]          valid_r;
  logic [SPAN_W-1:0]   span_r, span_nxt;
  level_t              peak5_r, low5_r, peak6_r, low6_r;
  sector_t             sector5_r, sector6_r;
  level_t              ramp6_r, ramp6_nxt;
  logic [RPROD_W-1:0]  rprod;
  level_t              up, down;
  level_t              red_r, green_r, blue_r;
  level_t              red_nxt, green_nxt, blue_nxt;

  always_comb begin
    span_nxt  = SPAN_W'(peak - low) * SPAN_W'(hue_info.offset);
    rprod     = RPROD_W'(span_r) * RPROD_W'(RAMP_RECIP);
    ramp6_nxt = LVL_W'(rprod >> RAMP_SHIFT);
    // ramp never exceeds peak - low, so neither leg wraps
    up        = low6_r + ramp6_r;
    down      = peak6_r - ramp6_r;
    case (sector6_r)
      SECT_RED_YEL: begin
        red_nxt = peak6_r; green_nxt = up;      blue_nxt = low6_r;
      end
      SECT_YEL_GRN: begin
        red_nxt = down;    green_nxt = peak6_r; blue_nxt = low6_r;
      end
      SECT_GRN_CYN: begin
        red_nxt = low6_r;  green_nxt = peak6_r; blue_nxt = up;
      end
      SECT_CYN_BLU: begin
        red_nxt = low6_r;  green_nxt = down;    blue_nxt = peak6_r;
      end
      SECT_BLU_MAG: begin
        red_nxt = up;      green_nxt = low6_r;  blue_nxt = peak6_r;
      end
      default: begin
        red_nxt = peak6_r; green_nxt = low6_r;  blue_nxt = down;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else begin
      valid_r <= {valid_r[1:0], hue_info.valid};
    end
  end

  always_ff @(posedge clk) begin
    span_r    <= span_nxt;
    peak5_r   <= peak;
    low5_r    <= low;
    sector5_r <= hue_info.sector;
    ramp6_r   <= ramp6_nxt;
    peak6_r   <= peak5_r;
    low6_r    <= low5_r;
    sector6_r <= sector5_r;
    red_r     <= red_nxt;
    green_r   <= green_nxt;
    blue_r    <= blue_nxt;
  end

  assign out_valid = valid_r[2];
  assign out_red   = red_r;
  assign out_green = green_r;
  assign out_blue  = blue_r;

endmodule

// ===== rtl/hsv_to_rgb_converter.sv =====
// HSV to RGB converter top level: hue and level paths feeding the mix stages.
// A taken word passes the hue/level stages, then the mix stages, to out_* and out_valid.
// Throughput: one word per cycle; busy stays low, the seven-stage pipeline never stalls.
// Reset (rst_n low, synchronous) clears the stage valid bits; data registers are not reset.
`timescale 1ns / 1ps
module hsv_to_rgb_converter (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic [hsv2rgb_pkg::HUE_W-1:0] in_hue,
  input  logic [hsv2rgb_pkg::PCT_W-1:0] in_saturation,
  input  logic [hsv2rgb_pkg::PCT_W-1:0] in_brightness,
  output logic                          out_valid,
  output logic [hsv2rgb_pkg::LVL_W-1:0] out_red,
  output logic [hsv2rgb_pkg::LVL_W-1:0] out_green,
  output logic [hsv2rgb_pkg::LVL_W-1:0] out_blue
);
  import hsv2rgb_pkg::*;

  hue_info_t hue_info;
  level_t    peak;
  level_t    low;

  assign busy = 1'b0;

  hsv2rgb_hue_split u_hue (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (start),
    .in_hue   (in_hue),
    .hue_info (hue_info)
  );

  hsv2rgb_level u_level (
    .clk           (clk),
    .in_saturation (in_saturation),
    .in_brightness (in_brightness),
    .peak          (peak),
    .low           (low)
  );

  hsv2rgb_mix u_mix (
    .clk       (clk),
    .rst_n     (rst_n),
    .hue_info  (hue_info),
    .peak      (peak),
    .low       (low),
    .out_valid (out_valid),
    .out_red   (out_red),
    .out_green (out_green),
    .out_blue  (out_blue)
  );

endmodule

// ===== rtl/hsv2rgb_checker.sv =====
// Port-level checker for the HSV to RGB converter, bound to the top level.
`timescale 1ns / 1ps
module hsv2rgb_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       start,
  input logic       busy,
  input logic [6:0] in_brightness,
  input logic       out_valid,
  input logic [7:0] out_red,
  input logic [7:0] out_green,
  input logic [7:0] out_blue
);

  a_never_busy: assert property (@(posedge clk) disable iff (!rst_n) !busy)
    else $error("busy raised");

  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##7 out_valid)
    else $error("accepted word not delivered after 7 cycles");

  a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
    !(start && !busy) |-> ##7 !out_valid)
    else $error("result without accepted word");

  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("out_valid after reset");

  a_black: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_brightness == 7'd0) |->
      ##7 (out_red == 8'd0 && out_green == 8'd0 && out_blue == 8'd0))
    else $error("zero brightness did not give black");

endmodule

bind hsv_to_rgb_converter hsv2rgb_checker u_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .start         (start),
  .busy          (busy),
  .in_brightness (in_brightness),
  .out_valid     (out_valid),
  .out_red       (out_red),
  .out_green     (out_green),
  .out_blue      (out_blue)
);
